[rtl/core/stg_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the sine tone generator
package stg_pkg;

  localparam int SMP_W       = 15;
  localparam int MAG_W       = 14;
  localparam int AMPLITUDE   = 16383;
  localparam int NOTE_W      = 8;
  localparam int DUR_W       = 16;
  localparam int FREQ_W      = 12;
  localparam int NOTE_AW     = 6;
  localparam int NOTE_MAX    = 61;
  localparam int DUR_MAX     = 65535;

  // duration scaling: ms * rate / 1000
  localparam int MS_PER_S    = 1000;
  localparam int MS_X_W      = 26;
  localparam int MS_RECIP    = (1 << MS_X_W) / MS_PER_S;
  localparam int MS_RECIP_W  = 17;
  localparam int LD_REM_W    = 11;

  // quarter wave series in Q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int Q30_SHIFT   = 30;

  // result buffer
  localparam int RES_FIFO_DEPTH = 16;
  localparam int RES_FIFO_AW    = 4;

  typedef logic [FREQ_W-1:0] freq_t;

  // tone frequencies in Hz, entry 0 unused
  localparam freq_t FREQ_ROM [NOTE_MAX+1] = '{
    12'd0,    12'd65,   12'd73,   12'd82,   12'd87,   12'd98,   12'd110,  12'd123,
    12'd131,  12'd147,  12'd165,  12'd175,  12'd196,  12'd220,  12'd233,  12'd247,
    12'd262,  12'd294,  12'd311,  12'd330,  12'd349,  12'd370,  12'd392,  12'd415,
    12'd440,  12'd494,  12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
    12'd740,  12'd784,  12'd831,  12'd880,  12'd932,  12'd988,  12'd1047, 12'd1109,
    12'd1175, 12'd1245, 12'd1319, 12'd1397, 12'd1480, 12'd1568, 12'd1661, 12'd1760,
    12'd1865, 12'd1976, 12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
    12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
  };

  typedef enum logic [1:0] {
    CTL_READY,
    CTL_SCALE,
    CTL_CORRECT,
    CTL_COMMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    ENV_FLAT,
    ENV_ATTACK,
    ENV_RELEASE
  } env_mode_t;

  typedef struct packed {
    logic rejected;
    logic last;
    logic sample_valid;
  } res_flags_t;

  typedef struct packed {
    res_flags_t              flags;
    logic signed [SMP_W-1:0] sample;
  } res_entry_t;

endpackage

[rtl/core/sine_tone_generator_unit.sv]
`timescale 1ns / 1ps
// sine tone generator: note loader, phase-to-address pipeline, sine rom, envelope, result buffer
//
// A word with in_tuser high is a start: in_tdata carries the note index (1 to 61) and the
// tone length in ms; a bad index is flagged as rejected and the tone in progress carries on.
// Every other word is a tick that yields the next sample of the tone, with out_tlast on the
// final one; a tick while idle gives an empty word. Every accepted word yields exactly one
// result word, in order. Ticks are taken one per clock while in_tready is high. A valid start
// keeps in_tready low through the scale, correct and commit states while the length in samples
// is worked out (constant multiply, a reciprocal multiply and one correction step). Each word
// passes through six pipeline stages, a 16-word buffer and an output register read from it;
// in_tready also drops while 16 words are outstanding, so a stalled output holds the input
// back only once the buffer is full. The sine table of SINE_TABLE_DEPTH entries is a rom
// built at elaboration and read into a register once per word; phase is turned
// into a rom address by a reciprocal multiply and a correction.
module sine_tone_generator_unit
  import stg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_RATE      = 44100
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // note_index [7:0], duration_ms [23:8]
  input  logic [0:0]  in_tuser,   // start_req [0]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // sample [14:0], zero pad [15]
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // sample_valid [0], rejected [1]
);

  // rom addressing
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
  localparam int PH_W   = $clog2(SAMPLE_RATE);
  localparam int PX_W   = $clog2(longint'(SAMPLE_RATE) * SINE_TABLE_DEPTH);
  localparam longint unsigned PH_RECIP = (64'd1 << PX_W) / SAMPLE_RATE;
  localparam int PH_RECIP_W = $clog2(PH_RECIP + 1);
  localparam int PH_PROD_W  = PX_W + PH_RECIP_W;

  // envelope
  localparam int ATT_LEN = SAMPLE_RATE / 100;
  localparam int REL_LEN = SAMPLE_RATE / 20;
  localparam int COEF_W  = $clog2(REL_LEN + 1);
  localparam int PROD_W  = MAG_W + COEF_W;
  localparam longint unsigned ENV_RECIP_ATT = (64'd1 << PROD_W) / ATT_LEN;
  localparam longint unsigned ENV_RECIP_REL = (64'd1 << PROD_W) / REL_LEN;
  localparam int ENV_RECIP_W = $clog2(ENV_RECIP_ATT + 1);
  localparam int ENV_PROD_W  = PROD_W + ENV_RECIP_W;

  // tone length
  localparam longint unsigned TOT_MAX = (longint'(SAMPLE_RATE) * DUR_MAX) / MS_PER_S;
  localparam int TOT_W     = $clog2(TOT_MAX + 1);
  localparam int RATE_KHZ  = SAMPLE_RATE / MS_PER_S;
  localparam int RATE_FRAC = SAMPLE_RATE % MS_PER_S;
  localparam int MS_PROD_W = MS_X_W + MS_RECIP_W;

  typedef logic signed [SMP_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // 16383*sin((pi/2)*m/depth), rounded, 0 <= m <= depth
  function automatic logic [MAG_W-1:0] quarter_mag(input longint unsigned m);
    longint unsigned a, a2, t, s, mg;
    if (m == 0) begin
      return '0;
    end
    if (m >= SINE_TABLE_DEPTH) begin
      return MAG_W'(AMPLITUDE);
    end
    if (3 * m == SINE_TABLE_DEPTH) begin
      return MAG_W'(8192);
    end
    a  = (HALF_PI_Q30 * m) / SINE_TABLE_DEPTH;
    a2 = (a * a) >> Q30_SHIFT;
    t  = a;
    s  = a;
    // alternating taylor terms, later terms are zero at this precision
    t = ((t * a2) >> Q30_SHIFT) / 6;   s = s - t;
    t = ((t * a2) >> Q30_SHIFT) / 20;  s = s + t;
    t = ((t * a2) >> Q30_SHIFT) / 42;  s = s - t;
    t = ((t * a2) >> Q30_SHIFT) / 72;  s = s + t;
    t = ((t * a2) >> Q30_SHIFT) / 110; s = s - t;
    t = ((t * a2) >> Q30_SHIFT) / 156; s = s + t;
    t = ((t * a2) >> Q30_SHIFT) / 210; s = s - t;
    t = ((t * a2) >> Q30_SHIFT) / 272; s = s + t;
    t = ((t * a2) >> Q30_SHIFT) / 342; s = s - t;
    t = ((t * a2) >> Q30_SHIFT) / 420; s = s + t;
    mg = (64'(AMPLITUDE) * s + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
    if (mg > AMPLITUDE) begin
      mg = AMPLITUDE;
    end
    return MAG_W'(mg);
  endfunction

  // full wave from the quarter wave by quadrant
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t              rom;
    longint unsigned        q, r, m;
    logic [MAG_W-1:0]       v;
    logic signed [SMP_W-1:0] vs;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q  = (4 * k) / SINE_TABLE_DEPTH;
      r  = 4 * k - q * SINE_TABLE_DEPTH;
      m  = q[0] ? SINE_TABLE_DEPTH - r : r;
      v  = quarter_mag(m);
      vs = $signed({1'b0, v});
      rom[k] = (q >= 2) ? -vs : vs;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // ---------------------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------------------
  logic              in_acc;
  logic              out_acc;
  logic              is_start;
  logic [NOTE_W-1:0] note_idx;
  logic [DUR_W-1:0]  dur_ms;
  logic              note_ok;
  logic              start_load;
  logic              tick_play;

  assign in_acc   = in_tvalid & in_tready;
  assign out_acc  = out_tvalid & out_tready;
  assign is_start = in_tuser[0];
  assign note_idx = in_tdata[NOTE_W-1:0];
  assign dur_ms   = in_tdata[NOTE_W +: DUR_W];
  assign note_ok  = (note_idx != '0) && (note_idx <= NOTE_W'(NOTE_MAX));

  // ---------------------------------------------------------------------------------------
  // tone state
  // ---------------------------------------------------------------------------------------
  ctl_state_t          ctl_state_r, ctl_state_nxt;
  logic                playing_r;
  freq_t               freq_r;
  logic [TOT_W-1:0]    tot_r;
  logic [TOT_W-1:0]    pos_r;
  logic [PH_W-1:0]     phase_r;

  // length scaling registers
  logic [MS_X_W-1:0]   ld_frac_r;
  logic [TOT_W-1:0]    ld_khz_r;
  logic [DUR_W-1:0]    ld_qe_r;
  logic [LD_REM_W-1:0] ld_rem_r;
  logic [MS_PROD_W-1:0] ld_prod;
  logic [MS_X_W-1:0]   ld_back;
  logic [MS_X_W-1:0]   ld_rem_full;
  logic [TOT_W-1:0]    tot_nxt;

  // controls from the load sequencer
  logic ctl_ready;
  logic ld_scale_en;
  logic ld_correct_en;
  logic ld_commit_en;

  assign start_load = in_acc && is_start && note_ok;
  assign tick_play  = in_acc && !is_start && playing_r;

  always_comb begin
    ctl_state_nxt = ctl_state_r;
    unique case (ctl_state_r)
      CTL_READY: begin
        if (start_load) begin
          ctl_state_nxt = CTL_SCALE;
        end
      end
      CTL_SCALE:   ctl_state_nxt = CTL_CORRECT;
      CTL_CORRECT: ctl_state_nxt = CTL_COMMIT;
      CTL_COMMIT:  ctl_state_nxt = CTL_READY;
      default:     ctl_state_nxt = CTL_READY;
    endcase
  end

  always_comb begin
    ctl_ready     = 1'b0;
    ld_scale_en   = 1'b0;
    ld_correct_en = 1'b0;
    ld_commit_en  = 1'b0;
    unique case (ctl_state_r)
      CTL_READY:   ctl_ready     = 1'b1;
      CTL_SCALE:   ld_scale_en   = 1'b1;
      CTL_CORRECT: ld_correct_en = 1'b1;
      CTL_COMMIT:  ld_commit_en  = 1'b1;
      default:     ctl_ready     = 1'b0;
    endcase
  end

  // floor(frac*ms/1000) by reciprocal, then one correction
  assign ld_prod     = MS_PROD_W'(ld_frac_r) * MS_PROD_W'(MS_RECIP);
  assign ld_back     = MS_X_W'(ld_qe_r) * MS_X_W'(MS_PER_S);
  assign ld_rem_full = ld_frac_r - ld_back;
  assign tot_nxt     = ld_khz_r + TOT_W'(ld_qe_r)
                     + TOT_W'(ld_rem_r >= LD_REM_W'(MS_PER_S));

  // per tick position and envelope decisions
  logic [TOT_W:0]     pos_inc;
  logic               tick_last;
  logic               in_attack;
  logic               in_release;
  logic [TOT_W-1:0]   remain;
  env_mode_t          env_mode;
  logic [COEF_W-1:0]  env_coef;
  logic [PH_W:0]      phase_sum;
  logic [PH_W-1:0]    phase_nxt;

  assign pos_inc    = {1'b0, pos_r} + (TOT_W+1)'(1);
  assign tick_last  = pos_inc >= {1'b0, tot_r};
  assign in_attack  = pos_r < TOT_W'(ATT_LEN);
  assign in_release = ({1'b0, pos_r} + (TOT_W+1)'(REL_LEN)) > {1'b0, tot_r};
  assign remain     = tot_r - pos_r;

  always_comb begin
    priority if (in_attack) begin
      env_mode = ENV_ATTACK;
      env_coef = pos_r[COEF_W-1:0];
    end else if (in_release) begin
      env_mode = ENV_RELEASE;
      env_coef = remain[COEF_W-1:0];
    end else begin
      env_mode = ENV_FLAT;
      env_coef = '0;
    end
  end

  // phase wraps once at most, the tone is below the sample rate
  assign phase_sum = {1'b0, phase_r} + (PH_W+1)'(freq_r);
  assign phase_nxt = (phase_sum >= (PH_W+1)'(SAMPLE_RATE))
                   ? PH_W'(phase_sum - (PH_W+1)'(SAMPLE_RATE))
                   : phase_sum[PH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_state_r <= CTL_READY;
      playing_r   <= 1'b0;
      freq_r      <= '0;
      tot_r       <= '0;
      pos_r       <= '0;
      phase_r     <= '0;
    end else begin
      ctl_state_r <= ctl_state_nxt;
      if (start_load) begin
        playing_r <= 1'b0;
        freq_r    <= FREQ_ROM[note_idx[NOTE_AW-1:0]];
        pos_r     <= '0;
        phase_r   <= '0;
      end else if (tick_play) begin
        pos_r   <= pos_inc[TOT_W-1:0];
        phase_r <= phase_nxt;
        if (tick_last) begin
          playing_r <= 1'b0;
        end
      end
      if (ld_commit_en) begin
        tot_r     <= tot_nxt;
        playing_r <= (tot_nxt != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_load) begin
      ld_frac_r <= MS_X_W'(RATE_FRAC) * MS_X_W'(dur_ms);
      ld_khz_r  <= TOT_W'(RATE_KHZ) * TOT_W'(dur_ms);
    end
    if (ld_scale_en) begin
      ld_qe_r <= DUR_W'(ld_prod >> MS_X_W);
    end
    if (ld_correct_en) begin
      ld_rem_r <= ld_rem_full[LD_REM_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------------------
  // sample pipeline
  // s1 phase*depth, s2 reciprocal quotient, s3 corrected address, s4 rom word,
  // s5 magnitude times envelope, s6 reciprocal quotient, then the buffer write
  // ---------------------------------------------------------------------------------------
  logic [6:1]             s_vld_r;
  res_flags_t             s1_flags_r, s2_flags_r, s3_flags_r, s4_flags_r, s5_flags_r, s6_flags_r;
  env_mode_t              s1_mode_r, s2_mode_r, s3_mode_r, s4_mode_r, s5_mode_r, s6_mode_r;
  logic [COEF_W-1:0]      s1_coef_r, s2_coef_r, s3_coef_r, s4_coef_r;
  logic [PX_W-1:0]        s1_x_r, s2_x_r;
  logic [ADDR_W-1:0]      s2_qe_r, s3_addr_r;
  logic signed [SMP_W-1:0] s4_rom_r;
  logic                   s5_neg_r, s6_neg_r;
  logic [MAG_W-1:0]       s5_mag_r, s6_mag_r;
  logic [PROD_W-1:0]      s5_prod_r, s6_prod_r;
  logic [MAG_W-1:0]       s6_qe_r;

  res_flags_t             s0_flags;
  logic [PH_PROD_W-1:0]   ph_prod;
  logic [PX_W-1:0]        ph_back;
  logic [PX_W-1:0]        ph_rem;
  logic [ADDR_W-1:0]      s3_addr_nxt;
  logic                   rom_neg;
  logic [MAG_W-1:0]       rom_mag;
  logic [ENV_RECIP_W-1:0] env_recip;
  logic [ENV_PROD_W-1:0]  env_prod;
  logic [PROD_W-1:0]      env_div;
  logic [PROD_W-1:0]      env_back;
  logic [PROD_W-1:0]      env_rem;
  logic [MAG_W-1:0]       env_mag;
  logic [MAG_W-1:0]       out_mag;
  res_entry_t             res_nxt;

  always_comb begin
    s0_flags.sample_valid = tick_play;
    s0_flags.last         = tick_play && tick_last;
    s0_flags.rejected     = in_acc && is_start && !note_ok;
  end

  // address = floor(x / rate), quotient low by at most one
  assign ph_prod     = PH_PROD_W'(s1_x_r) * PH_PROD_W'(PH_RECIP);
  assign ph_back     = PX_W'(s2_qe_r) * PX_W'(SAMPLE_RATE);
  assign ph_rem      = s2_x_r - ph_back;
  assign s3_addr_nxt = (ph_rem >= PX_W'(SAMPLE_RATE)) ? s2_qe_r + ADDR_W'(1) : s2_qe_r;

  assign rom_neg = s4_rom_r[SMP_W-1];
  assign rom_mag = rom_neg ? MAG_W'(-s4_rom_r) : MAG_W'(s4_rom_r);

  // envelope divide by attack or release length, truncating
  assign env_recip = (s5_mode_r == ENV_ATTACK) ? ENV_RECIP_W'(ENV_RECIP_ATT)
                                               : ENV_RECIP_W'(ENV_RECIP_REL);
  assign env_prod  = ENV_PROD_W'(s5_prod_r) * ENV_PROD_W'(env_recip);
  assign env_div   = (s6_mode_r == ENV_ATTACK) ? PROD_W'(ATT_LEN) : PROD_W'(REL_LEN);
  assign env_back  = PROD_W'(s6_qe_r) * env_div;
  assign env_rem   = s6_prod_r - env_back;
  assign env_mag   = (env_rem >= env_div) ? s6_qe_r + MAG_W'(1) : s6_qe_r;
  assign out_mag   = (s6_mode_r == ENV_FLAT) ? s6_mag_r : env_mag;

  always_comb begin
    res_nxt.flags = s6_flags_r;
    if (!s6_flags_r.sample_valid) begin
      res_nxt.sample = '0;
    end else if (s6_neg_r) begin
      res_nxt.sample = -$signed({1'b0, out_mag});
    end else begin
      res_nxt.sample = $signed({1'b0, out_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= '0;
    end else begin
      s_vld_r <= {s_vld_r[5:1], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    // s1
    s1_flags_r <= s0_flags;
    s1_mode_r  <= env_mode;
    s1_coef_r  <= env_coef;
    s1_x_r     <= PX_W'(phase_r) * PX_W'(SINE_TABLE_DEPTH);
    // s2
    s2_flags_r <= s1_flags_r;
    s2_mode_r  <= s1_mode_r;
    s2_coef_r  <= s1_coef_r;
    s2_x_r     <= s1_x_r;
    s2_qe_r    <= ADDR_W'(ph_prod >> PX_W);
    // s3
    s3_flags_r <= s2_flags_r;
    s3_mode_r  <= s2_mode_r;
    s3_coef_r  <= s2_coef_r;
    s3_addr_r  <= s3_addr_nxt;
    // s4: rom read
    s4_flags_r <= s3_flags_r;
    s4_mode_r  <= s3_mode_r;
    s4_coef_r  <= s3_coef_r;
    s4_rom_r   <= SINE_ROM[s3_addr_r];
    // s5
    s5_flags_r <= s4_flags_r;
    s5_mode_r  <= s4_mode_r;
    s5_neg_r   <= rom_neg;
    s5_mag_r   <= rom_mag;
    s5_prod_r  <= PROD_W'(rom_mag) * PROD_W'(s4_coef_r);
    // s6
    s6_flags_r <= s5_flags_r;
    s6_mode_r  <= s5_mode_r;
    s6_neg_r   <= s5_neg_r;
    s6_mag_r   <= s5_mag_r;
    s6_prod_r  <= s5_prod_r;
    s6_qe_r    <= MAG_W'(env_prod >> PROD_W);
  end

  // ---------------------------------------------------------------------------------------
  // result buffer; credit counts words accepted and not yet delivered, so it never overflows
  // the head word is read into the output register whenever that register is free or
  // being emptied, so only words already stored are ever read
  // ---------------------------------------------------------------------------------------
  res_entry_t             fifo_mem [RES_FIFO_DEPTH];
  logic [RES_FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RES_FIFO_AW:0]   fill_r, fill_nxt;
  logic [RES_FIFO_AW:0]   credit_r, credit_nxt;
  logic                   fifo_wr;
  logic                   fifo_rd;
  logic                   out_vld_r;
  res_entry_t             out_word_r;

  assign fifo_wr    = s_vld_r[6];
  assign fifo_rd    = (fill_r != '0) && (!out_vld_r || out_acc);
  assign fill_nxt   = fill_r + (RES_FIFO_AW+1)'(fifo_wr) - (RES_FIFO_AW+1)'(fifo_rd);
  assign credit_nxt = credit_r + (RES_FIFO_AW+1)'(in_acc) - (RES_FIFO_AW+1)'(out_acc);
  assign in_tready  = ctl_ready && (credit_r < (RES_FIFO_AW+1)'(RES_FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      fill_r    <= '0;
      credit_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      credit_r <= credit_nxt;
      if (fifo_wr) begin
        wr_ptr_r <= wr_ptr_r + RES_FIFO_AW'(1);
      end
      if (fifo_rd) begin
        rd_ptr_r  <= rd_ptr_r + RES_FIFO_AW'(1);
        out_vld_r <= 1'b1;
      end else if (out_acc) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_mem[wr_ptr_r] <= res_nxt;
    end
    if (fifo_rd) begin
      out_word_r <= fifo_mem[rd_ptr_r];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_word_r.sample};
  assign out_tlast  = out_word_r.flags.last;
  assign out_tuser  = {out_word_r.flags.rejected, out_word_r.flags.sample_valid};

endmodule

[rtl/core/stg_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the sine tone generator and their binding
module stg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled result word changed");

  // a rejected start carries no sample and no end mark
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && !out_tlast)
    else $error("rejected word marked as sample");

  // end of tone only on a real sample
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("last on empty word");

  // empty words are silent and samples stay inside full scale
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] || out_tdata == 16'd0) && out_tdata[15] == 1'b0
      && out_tdata[14:0] != 15'h4000)
    else $error("sample out of range or non-zero empty word");

endmodule

bind sine_tone_generator_unit stg_checker u_stg_checker (.*);

[tb/tone_word_checker.sv]
`timescale 1ns / 1ps
// watches both streams of the tone generator, predicts every result word and compares
module tone_word_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // note_index [7:0], duration_ms [23:8]
  input  logic [0:0]  in_tuser,   // start_req [0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // sample [14:0], zero pad [15]
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser,  // sample_valid [0], rejected [1]
  output int          mismatch_count,
  output int          words_pending
);

  localparam int TAB_DEPTH = 1024;
  localparam int RATE      = 44100;
  localparam int NOTE_LAST = 61;
  localparam int AMP       = 16383;
  localparam int ATTACK    = RATE / 100;
  localparam int RELEASE   = RATE / 20;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int NOTE_HZ [0:NOTE_LAST] = '{
    0,    65,   73,   82,   87,   98,   110,  123,  131,  147,  165,  175,  196,
    220,  233,  247,  262,  294,  311,  330,  349,  370,  392,  415,  440,
    494,  523,  554,  587,  622,  659,  698,  740,  784,  831,  880,  932,
    988,  1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865,
    1976, 2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729,
    3951
  };

  typedef struct packed {
    logic signed [14:0] sample;
    logic               valid;
    logic               last;
    logic               rejected;
  } tone_word_t;

  int          sine_tab [TAB_DEPTH];
  tone_word_t  expected_words [$];

  // tone state as the block should hold it
  logic [11:0] tone_hz;
  logic [21:0] tone_len;
  logic [21:0] tone_pos;
  logic [15:0] phase_acc;
  logic        playing;

  // quarter wave by a q2.30 series, mirrored into the other three quadrants
  initial begin : build_sine
    longint unsigned q, r, m, a, a2, term, acc, mag;
    int n;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      q = (4 * k) / TAB_DEPTH;
      r = 4 * k - q * TAB_DEPTH;
      m = q[0] ? TAB_DEPTH - r : r;
      if (m == 0) begin
        mag = 0;
      end else if (m >= TAB_DEPTH) begin
        mag = AMP;
      end else if (3 * m == TAB_DEPTH) begin
        mag = 8192;
      end else begin
        a    = HALF_PI_Q30 * m / TAB_DEPTH;
        a2   = (a * a) >> 30;
        term = a;
        acc  = a;
        n    = 1;
        while (n < 20) begin
          term = ((term * a2) >> 30) / ((2 * n) * (2 * n + 1));
          if (term == 0) begin
            n = 20;
          end else begin
            if (n % 2) acc = acc - term;
            else acc = acc + term;
            n++;
          end
        end
        mag = (AMP * acc + (64'd1 << 29)) >> 30;
        if (mag > AMP) mag = AMP;
      end
      sine_tab[k] = (q >= 2) ? -int'(mag) : int'(mag);
    end
  end

  // next result word for one accepted input word, advancing the tone state
  function automatic tone_word_t predict_tone_word(logic start, logic [23:0] data);
    tone_word_t w;
    longint idx, ms, i, tot, ridx, mag;
    int base, val;
    w = '0;
    if (start) begin
      idx = data[7:0];
      ms  = data[23:8];
      if (idx < 1 || idx > NOTE_LAST) begin
        w.rejected = 1'b1;
      end else begin
        tone_hz   = 12'(NOTE_HZ[idx]);
        tone_len  = 22'(longint'(RATE) * ms / 1000);
        tone_pos  = '0;
        phase_acc = '0;
        playing   = (tone_len != 0);
      end
    end else if (playing) begin
      i    = tone_pos;
      tot  = tone_len;
      ridx = longint'(phase_acc) * TAB_DEPTH / RATE;
      base = sine_tab[ridx];
      mag  = (base < 0) ? -base : base;
      if (i < ATTACK) mag = mag * i / ATTACK;
      else if (i + RELEASE > tot) mag = mag * ((tot > i) ? tot - i : 0) / RELEASE;
      val = (base < 0) ? -int'(mag) : int'(mag);
      w.sample = val[14:0];
      w.valid  = 1'b1;
      w.last   = (i + 1 >= tot);
      tone_pos  = 22'(i + 1);
      phase_acc = 16'((longint'(phase_acc) + tone_hz) % RATE);
      if (w.last) playing = 1'b0;
    end
    return w;
  endfunction

  always @(posedge clk) begin : watch
    tone_word_t exp_w;
    if (!rst_n) begin
      tone_hz   = '0;
      tone_len  = '0;
      tone_pos  = '0;
      phase_acc = '0;
      playing   = 1'b0;
      mismatch_count = 0;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result word data %h last %b user %b",
                     $realtime, out_tdata, out_tlast, out_tuser);
        end else begin
          exp_w = expected_words.pop_front();
          if ({out_tdata, out_tlast, out_tuser} !==
              {1'b0, exp_w.sample, exp_w.last, exp_w.rejected, exp_w.valid}) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected %0d v%b l%b r%b, got %0d pad %b v%b l%b r%b",
                       $realtime, exp_w.sample, exp_w.valid, exp_w.last, exp_w.rejected,
                       $signed(out_tdata[14:0]), out_tdata[15], out_tuser[0], out_tlast,
                       out_tuser[1]);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_words.insert(expected_words.size(),
                              predict_tone_word(in_tuser[0], in_tdata));
    end
    words_pending = expected_words.size();
  end

endmodule

[tb/sine_tone_generator_unit_test.sv]
`timescale 1ns / 1ps
// top of the tone generator regression: clock, reset, stimulus, receiver stalls and verdict
module sine_tone_generator_unit_test;

  localparam int RANDOM_WORDS = 1800;
  localparam int HOLD_CYCLES  = 200;     // long output hold-off, well past the 16-word buffer
  localparam int SETTLE       = 16;      // margin past the result pipeline and output register
  localparam int LIMIT_NS     = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // note_index [7:0], duration_ms [23:8]
  logic [0:0]  in_tuser;   // start_req [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // sample [14:0], zero pad [15]
  logic        out_tlast;
  logic [1:0]  out_tuser;  // sample_valid [0], rejected [1]

  int mismatch_count;
  int words_pending;
  int words_sent;
  int burst_left;
  bit hold_req;

  sine_tone_generator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  tone_word_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // hard stop in case a handshake never completes
  initial begin
    #(LIMIT_NS);
    $display("sine_tone_generator_unit regression: fail");
    $finish;
  end

  // an index of 0 or anything above the top note
  function automatic logic [7:0] bad_note();
    int pick;
    pick = $urandom_range(0, 194);
    return (pick == 0) ? 8'd0 : 8'(pick + 61);
  endfunction

  // offer one word and hold it until it is taken; called and returns at a falling edge.
  // the sender runs in bursts, a gap of idle cycles falls between them
  task automatic send_word(logic start, logic [7:0] note, logic [15:0] ms);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      // a quarter of the bursts are long stretches with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= {ms, note};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  // stop offering until every expected result word is back, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // a start followed by ticks with junk in tdata; now and then a bad start lands mid-tone
  task automatic play_tone(logic [7:0] note, logic [15:0] ms, int ticks);
    send_word(1'b1, note, ms);
    for (int t = 0; t < ticks; t++) begin
      if ($urandom_range(0, 59) == 0) send_word(1'b1, bad_note(), 16'($urandom));
      send_word(1'b0, 8'($urandom), 16'($urandom));
    end
  endtask

  // receiver: switches among random stall patterns, and once holds off for a
  // long stretch on request so that the result buffer fills and the input backs up
  initial begin : receiver
    int mode, left;
    bit held;
    out_tready = 1'b0;
    mode = 0;
    left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_tready <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    int sel;
    int len;
    bit hold_done;
    logic [7:0] note;
    logic [15:0] ms;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    words_sent = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: tick while idle, bad indexes at both ends, zero length tone
    send_word(1'b0, 8'h00, 16'h0000);
    send_word(1'b1, 8'd0, 16'hFFFF);
    send_word(1'b1, 8'd62, 16'h0000);
    send_word(1'b1, 8'd255, 16'h5A5A);
    send_word(1'b1, 8'd61, 16'h0000);
    send_word(1'b0, 8'hFF, 16'hFFFF);
    // longest tone on the lowest note, a bad start must not disturb it
    send_word(1'b1, 8'd1, 16'hFFFF);
    repeat (3) send_word(1'b0, 8'($urandom), 16'($urandom));
    send_word(1'b1, 8'd128, 16'h0001);
    repeat (2) send_word(1'b0, 8'($urandom), 16'($urandom));
    // valid starts mid-tone drop the old tone, top note and shortest length
    send_word(1'b1, 8'd61, 16'h0001);
    repeat (4) send_word(1'b0, 8'($urandom), 16'($urandom));
    send_word(1'b1, 8'd33, 16'h8000);
    repeat (2) send_word(1'b0, 8'($urandom), 16'($urandom));
    drain();

    // random: mostly whole tones played to their last sample, the rest noise
    while (words_sent < RANDOM_WORDS + 21) begin
      if (!hold_done && words_sent > 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      sel  = $urandom_range(0, 99);
      note = 8'($urandom_range(1, 61));
      if (sel < 80) begin
        // short tones stay in attack, 11 ms and up reach the release
        ms  = (sel < 50) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(4, 12));
        len = 44100 * ms / 1000;
        play_tone(note, ms, len + $urandom_range(0, 2));
      end else if (sel < 83) begin
        // long tone cut off a while after the attack, covers the flat part
        play_tone(note, 16'($urandom_range(100, 65535)), $urandom_range(450, 600));
      end else if (sel < 88) begin
        ms  = 16'($urandom_range(1, 12));
        len = 44100 * ms / 1000;
        play_tone(note, ms, $urandom_range(0, len - 1));
      end else if (sel < 95) begin
        if ($urandom_range(0, 1)) note = bad_note();
        else note = 8'($urandom);
        send_word(1'b1, note, 16'($urandom));
        repeat ($urandom_range(0, 3)) send_word(1'b0, 8'($urandom), 16'($urandom));
      end else if (sel < 97) begin
        drain();
      end else begin
        repeat ($urandom_range(1, 4)) send_word(1'b0, 8'($urandom), 16'($urandom));
      end
    end

    drain();
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("sine_tone_generator_unit regression: pass");
    end else begin
      $display("sine_tone_generator_unit regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/stg_pkg.sv
rtl/core/sine_tone_generator_unit.sv
rtl/core/stg_checker.sv
tb/tone_word_checker.sv
tb/sine_tone_generator_unit_test.sv
